>>> design/psb_pkg.sv
// Package for the phone syllable boundary block.
// Holds the phone categories, rule codes, queue entry and handshake structs.
// No dependencies; psb_front, psb_fifo, psb_back and the top level import it.
package psb_pkg;

    typedef enum logic [2:0] {
        CAT_UNKNOWN = 3'd0,
        CAT_PAUSE   = 3'd1,
        CAT_STOP    = 3'd2,
        CAT_FRIC    = 3'd3,
        CAT_LIQUID  = 3'd4,
        CAT_GLIDE   = 3'd5,
        CAT_VOWEL   = 3'd6
    } t_cat;

    // Which of the up to three results of one queued entry is being produced.
    typedef enum logic [1:0] {
        STEP_STEADY = 2'd0,
        STEP_TAIL   = 2'd1,
        STEP_FINAL  = 2'd2
    } t_step;

    localparam int RULE_W = 6;
    typedef logic [RULE_W-1:0] t_rule;

    localparam t_rule RULE_NONE = 6'd0;
    localparam t_rule RULE_6A   = 6'd1;
    localparam t_rule RULE_5A   = 6'd2;
    localparam t_rule RULE_5B   = 6'd3;
    localparam t_rule RULE_5C   = 6'd4;
    localparam t_rule RULE_5D   = 6'd5;
    localparam t_rule RULE_5E   = 6'd6;
    localparam t_rule RULE_5F   = 6'd7;
    localparam t_rule RULE_5G   = 6'd8;
    localparam t_rule RULE_4A   = 6'd9;
    localparam t_rule RULE_4B   = 6'd10;
    localparam t_rule RULE_4C   = 6'd11;
    localparam t_rule RULE_4D   = 6'd12;
    localparam t_rule RULE_4E   = 6'd13;
    localparam t_rule RULE_4F   = 6'd14;
    localparam t_rule RULE_4G   = 6'd15;
    localparam t_rule RULE_4H   = 6'd16;
    localparam t_rule RULE_4I   = 6'd17;
    localparam t_rule RULE_3A   = 6'd18;
    localparam t_rule RULE_3B   = 6'd19;
    localparam t_rule RULE_3C   = 6'd20;
    localparam t_rule RULE_3D   = 6'd21;
    localparam t_rule RULE_3E   = 6'd22;
    localparam t_rule RULE_3F   = 6'd23;
    localparam t_rule RULE_3G   = 6'd24;
    localparam t_rule RULE_3H   = 6'd25;
    localparam t_rule RULE_3I   = 6'd26;
    localparam t_rule RULE_3J   = 6'd27;
    localparam t_rule RULE_3K   = 6'd28;
    localparam t_rule RULE_2A   = 6'd29;
    localparam t_rule RULE_2B   = 6'd30;
    localparam t_rule RULE_2C   = 6'd31;
    localparam t_rule RULE_2D   = 6'd32;
    localparam t_rule RULE_2E   = 6'd33;
    localparam t_rule RULE_2F   = 6'd34;
    localparam t_rule RULE_2G   = 6'd35;
    localparam t_rule RULE_2H   = 6'd36;
    localparam t_rule RULE_2I   = 6'd37;
    localparam t_rule RULE_2J   = 6'd38;
    localparam t_rule RULE_2K   = 6'd39;
    localparam t_rule RULE_2L   = 6'd40;
    localparam t_rule RULE_2M   = 6'd41;
    localparam t_rule RULE_2N   = 6'd42;

    // One queued phone: window as it stood before the phone, the phone itself,
    // how many phones came before it (saturating) and the end-of-sequence flag.
    typedef struct packed {
        t_cat       w0;
        t_cat       w1;
        t_cat       w2;
        t_cat       w3;
        t_cat       cat;
        logic [1:0] seen;
        logic       last;
    } t_task;

    typedef struct packed {
        logic  valid;
        t_task item;
    } t_push;

    typedef struct packed {
        logic  valid;
        t_task item;
    } t_head;

endpackage

>>> design/psb_if.sv
// Handshake interfaces for the phone and result channels.
// Depends on nothing; used by psb_front, psb_back and the top level.
interface psb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_char;
    logic       is_pause;
    logic       is_double_j;
    logic       last_phone;

    modport source (output valid, first_char, is_pause, is_double_j, last_phone,
                    input ready);
    modport sink   (input valid, first_char, is_pause, is_double_j, last_phone,
                    output ready);
endinterface

interface psb_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] phone_category;
    logic       merge_with_previous;
    logic [5:0] rule_fired;
    logic       last_result;

    modport source (output valid, phone_category, merge_with_previous, rule_fired,
                    last_result, input ready);
    modport sink   (input valid, phone_category, merge_with_previous, rule_fired,
                    last_result, output ready);
endinterface

>>> design/psb_front.sv
// Front end: accept phones, classify them and keep the category window.
// Depends on psb_pkg and psb_in_if; pushes entries into psb_fifo.
module psb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    psb_in_if.sink         i_phone,
    input  logic           i_full,
    output psb_pkg::t_push o_push
);
    import psb_pkg::*;

    function automatic t_cat categorize(input logic [7:0] ch, input logic pause,
                                        input logic dj);
        t_cat res;
        res = CAT_UNKNOWN;
        if (pause) begin
            res = CAT_PAUSE;
        end else if (ch inside {"a", "A", "e", "E", "o", "O", "i", "u", "y", "@",
                                "2", "6", "9"}) begin
            res = CAT_VOWEL;
        end else if (ch inside {"B", "G", "p", "t", "k", "b", "d", "g", "f", "v",
                                "c"}) begin
            res = CAT_STOP;
        end else if (ch inside {"T", "D", "s", "S", "z", "Z", "m", "n", "N",
                                "J"}) begin
            res = CAT_FRIC;
        end else if (dj) begin
            res = CAT_FRIC;
        end else if (ch inside {"l", "L", "r", "R", "X", "x", "h", "4"}) begin
            res = CAT_LIQUID;
        end else if (ch inside {"j", "w", "H"}) begin
            res = CAT_GLIDE;
        end
        return res;
    endfunction

    t_cat       r_win [4];
    logic [1:0] r_seen;
    t_cat       cat;
    logic       accept;

    assign i_phone.ready = !i_full;
    assign accept        = i_phone.valid && !i_full;
    assign cat           = categorize(i_phone.first_char, i_phone.is_pause,
                                      i_phone.is_double_j);

    // Queue only phones that release results: steady stream or a flush.
    always_comb begin
        o_push.valid     = accept && (r_seen[1] || i_phone.last_phone);
        o_push.item.w0   = r_win[0];
        o_push.item.w1   = r_win[1];
        o_push.item.w2   = r_win[2];
        o_push.item.w3   = r_win[3];
        o_push.item.cat  = cat;
        o_push.item.seen = r_seen;
        o_push.item.last = i_phone.last_phone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= CAT_UNKNOWN;
            r_win[1] <= CAT_UNKNOWN;
            r_win[2] <= CAT_UNKNOWN;
            r_win[3] <= CAT_UNKNOWN;
            r_seen   <= 2'd0;
        end else if (accept) begin
            if (i_phone.last_phone) begin
                // end of sequence: start the next one from an empty window
                r_win[0] <= CAT_UNKNOWN;
                r_win[1] <= CAT_UNKNOWN;
                r_win[2] <= CAT_UNKNOWN;
                r_win[3] <= CAT_UNKNOWN;
                r_seen   <= 2'd0;
            end else begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= r_win[3];
                r_win[3] <= cat;
                if (r_seen != 2'd3) begin
                    r_seen <= r_seen + 2'd1;
                end
            end
        end
    end

endmodule

>>> design/psb_fifo.sv
// Short queue of classified phones between the front and back ends.
// Depends on psb_pkg.
module psb_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  psb_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output psb_pkg::t_head o_head
);
    import psb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_task             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push.valid) - CNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from an empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_count == CNT_W'($past(r_count)
            + CNT_W'($past(i_push.valid)) - CNT_W'($past(i_pop))))
        else $error("queue fill count out of step");

endmodule

>>> design/psb_back.sv
// Back end: expand each queued phone into its results, decode the rules
// and hold the result in an output register. Depends on psb_pkg, psb_out_if.
module psb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  psb_pkg::t_head i_head,
    output logic           o_pop,
    psb_out_if.source      o_result
);
    import psb_pkg::*;

    function automatic t_rule decide(input t_cat pp, input t_cat p, input t_cat c,
                                     input t_cat n, input t_cat nn);
        case (c)
            CAT_VOWEL: begin
                if (p inside {[CAT_STOP:CAT_GLIDE]}) return RULE_6A;
            end
            CAT_GLIDE: begin
                if (p == CAT_STOP) begin
                    if (n == CAT_VOWEL) return RULE_5A;
                end else if (p == CAT_FRIC) begin
                    if (n == CAT_FRIC) return RULE_5B;
                    if (n == CAT_VOWEL) return RULE_5C;
                    if (n == CAT_LIQUID) return RULE_5D;
                    if (n == CAT_PAUSE) return RULE_5E;
                end else if (p == CAT_LIQUID) begin
                    if (n == CAT_VOWEL) return RULE_5F;
                end else if (p == CAT_VOWEL) begin
                    if (n inside {[CAT_PAUSE:CAT_GLIDE]}) return RULE_5G;
                end
            end
            CAT_LIQUID: begin
                if (p == CAT_STOP) begin
                    if (n inside {CAT_PAUSE, CAT_GLIDE, CAT_VOWEL}) return RULE_4A;
                    if (n == CAT_STOP && nn == CAT_VOWEL && pp == CAT_VOWEL)
                        return RULE_4B;
                    if (n == CAT_STOP && nn == CAT_VOWEL && pp == CAT_FRIC)
                        return RULE_4C;
                    if (n == CAT_STOP && nn == CAT_LIQUID && pp == CAT_VOWEL)
                        return RULE_4D;
                    if (n == CAT_FRIC && pp == CAT_VOWEL) return RULE_4E;
                    if (n == CAT_FRIC && pp == CAT_FRIC) return RULE_4F;
                    if (n == CAT_LIQUID) return RULE_4G;
                end else if (p inside {CAT_LIQUID, CAT_GLIDE}) begin
                    if (n inside {CAT_STOP, CAT_PAUSE}) return RULE_4H;
                end else if (p == CAT_VOWEL) begin
                    if (n inside {[CAT_PAUSE:CAT_LIQUID]}) return RULE_4I;
                end
            end
            CAT_FRIC: begin
                if (p == CAT_VOWEL) begin
                    if (n inside {[CAT_PAUSE:CAT_LIQUID]}) return RULE_3A;
                    if (n == CAT_GLIDE && nn inside {CAT_FRIC, CAT_LIQUID, CAT_PAUSE})
                        return RULE_3B;
                end else if (p == CAT_LIQUID) begin
                    if (n inside {[CAT_PAUSE:CAT_FRIC]}) return RULE_3C;
                    if (n == CAT_VOWEL && pp == CAT_PAUSE) return RULE_3D;
                end else if (p == CAT_FRIC) begin
                    if (n inside {CAT_PAUSE, CAT_STOP}) return RULE_3E;
                    if (pp == CAT_PAUSE) return RULE_3F;
                end else if (p == CAT_STOP) begin
                    if (pp == CAT_PAUSE) return RULE_3G;
                    if (pp == CAT_LIQUID) return RULE_3H;
                    if (pp == CAT_VOWEL && n == CAT_FRIC) return RULE_3I;
                    if (pp == CAT_VOWEL && n == CAT_PAUSE) return RULE_3J;
                    if (pp == CAT_GLIDE) return RULE_3K;
                end
            end
            CAT_STOP: begin
                if (p == CAT_VOWEL) begin
                    if (n inside {CAT_PAUSE, CAT_STOP}) return RULE_2A;
                    if (n == CAT_FRIC) begin
                        if (nn inside {CAT_STOP, CAT_VOWEL, CAT_GLIDE, CAT_FRIC})
                            return RULE_2B;
                        if (nn == CAT_PAUSE) return RULE_2C;
                    end else if (n == CAT_LIQUID) begin
                        if (nn inside {[CAT_PAUSE:CAT_LIQUID]}) return RULE_2D;
                    end
                end else if (p == CAT_FRIC) begin
                    if (n inside {CAT_STOP, CAT_PAUSE}) return RULE_2E;
                    if (n == CAT_LIQUID && nn == CAT_PAUSE) return RULE_2F;
                    if (n == CAT_LIQUID && nn inside {CAT_FRIC, CAT_STOP, CAT_LIQUID})
                        return RULE_2G;
                    if (n == CAT_VOWEL && pp == CAT_FRIC) return RULE_2H;
                    if (pp inside {CAT_STOP, CAT_PAUSE}) return RULE_2I;
                end else if (p == CAT_LIQUID) begin
                    if (n == CAT_STOP) return RULE_2J;
                    if (n == CAT_PAUSE) return RULE_2K;
                    if (n == CAT_LIQUID && nn == CAT_PAUSE) return RULE_2L;
                    if (pp == CAT_PAUSE) return RULE_2M;
                end else if (p == CAT_STOP) begin
                    if (pp == CAT_PAUSE) return RULE_2N;
                end
            end
            default: begin
            end
        endcase
        return RULE_NONE;
    endfunction

    t_step      r_step;
    t_step      n_step;
    t_step      cur;
    logic [2:0] has_step;
    logic       done;
    logic       load;
    logic       fire;
    t_cat       op_pp, op_p, op_c, op_n, op_nn;
    logic       op_first;
    t_rule      rule;

    logic       r_valid;
    t_cat       r_cat;
    logic       r_merge;
    t_rule      r_rule;
    logic       r_last;

    // steady result needs two phones before; tail needs one and a flush; final needs a flush
    assign has_step[0] = i_head.item.seen[1];
    assign has_step[1] = i_head.item.last && (i_head.item.seen != 2'd0);
    assign has_step[2] = i_head.item.last;

    assign load = !r_valid || o_result.ready;
    assign fire = i_head.valid && load;

    always_comb begin
        if (r_step == STEP_STEADY && has_step[0]) begin
            cur = STEP_STEADY;
        end else if (r_step != STEP_FINAL && has_step[1]) begin
            cur = STEP_TAIL;
        end else begin
            cur = STEP_FINAL;
        end
        done  = (cur == STEP_FINAL) || (cur == STEP_STEADY && !i_head.item.last);
        o_pop = fire && done;

        n_step = r_step;
        if (fire) begin
            case (cur)
                STEP_STEADY: n_step = done ? STEP_STEADY : STEP_TAIL;
                STEP_TAIL:   n_step = STEP_FINAL;
                default:     n_step = STEP_STEADY;
            endcase
        end

        case (cur)
            STEP_STEADY: begin
                op_pp    = i_head.item.w0;
                op_p     = i_head.item.w1;
                op_c     = i_head.item.w2;
                op_n     = i_head.item.w3;
                op_nn    = i_head.item.cat;
                op_first = (i_head.item.seen == 2'd2);
            end
            STEP_TAIL: begin
                op_pp    = i_head.item.w1;
                op_p     = i_head.item.w2;
                op_c     = i_head.item.w3;
                op_n     = i_head.item.cat;
                op_nn    = CAT_UNKNOWN;
                op_first = (i_head.item.seen == 2'd1);
            end
            default: begin
                op_pp    = i_head.item.w2;
                op_p     = i_head.item.w3;
                op_c     = i_head.item.cat;
                op_n     = CAT_UNKNOWN;
                op_nn    = CAT_UNKNOWN;
                op_first = (i_head.item.seen == 2'd0);
            end
        endcase

        rule = op_first ? RULE_NONE : decide(op_pp, op_p, op_c, op_n, op_nn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_STEADY;
            r_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (fire) begin
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cat   <= op_c;
            r_merge <= (rule != RULE_NONE);
            r_rule  <= rule;
            r_last  <= (cur == STEP_FINAL);
        end
    end

    assign o_result.valid               = r_valid;
    assign o_result.phone_category      = r_cat;
    assign o_result.merge_with_previous = r_merge;
    assign o_result.rule_fired          = r_rule;
    assign o_result.last_result         = r_last;

    a_entry_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head.valid |-> has_step != 3'b000)
        else $error("queued entry yields no result");

    a_step_idle_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_step == STEP_STEADY)
        else $error("step counter not rewound after pop");

    a_final_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && cur == STEP_FINAL) |-> i_head.item.last && o_pop)
        else $error("final result outside a flush");

endmodule

>>> design/phone_syllable_boundary_rules.sv
// Top level of the phone syllable boundary block.
// Depends on psb_pkg, psb_if, psb_front, psb_fifo and psb_back.
//
// Use:
//   i_phone carries one phone label per transaction: its first character and
//   the pause, jj and end-of-sequence flags. o_result carries one decision per
//   phone, in phone order: category, merge flag, rule number, last flag.
//   Results trail the input by two phones. A phone flagged last releases every
//   result still pending (up to three) and clears the window for the next
//   sequence.
// Result path and throughput:
//   A releasing phone is written into the queue; the back end decodes the queue
//   head into the output register, from which the receiver takes the result. In
//   a steady stream one phone is taken every cycle while the queue is not full.
//   A flush occupies the back end for each released result in turn (up to
//   three), set by the single rule decoder and output register; the queue of
//   QUEUE_DEPTH entries keeps taking phones meanwhile.
// Reset:
//   Synchronous, active low. Clears the window, phone count, queue and output
//   valid; the block takes phones as soon as reset is released.
// Stall:
//   When the receiver holds ready low the output register holds its result,
//   the queue fills and i_phone.ready falls once QUEUE_DEPTH entries wait.
module phone_syllable_boundary_rules #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psb_in_if.sink    i_phone,
    psb_out_if.source o_result
);
    import psb_pkg::*;

    t_push push;
    t_head head;
    logic  full;
    logic  pop;

    // classify, slide the window, queue phones that release results
    psb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_phone (i_phone),
        .i_full  (full),
        .o_push  (push)
    );

    // decouple intake from result delivery
    psb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // expand each entry, decode rules, drive the output register
    psb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
